FILE: rtl/core/chkvs_pkg.sv
`default_nettype none
package chkvs_pkg;

   localparam logic [2:0] OP_INSERT     = 3'd0;
   localparam logic [2:0] OP_SEARCH     = 3'd1;
   localparam logic [2:0] OP_DELETE     = 3'd2;
   localparam logic [2:0] OP_CLR_BUCKET = 3'd3;
   localparam logic [2:0] OP_CLR_ALL    = 3'd4;

   localparam logic [3:0] STAT_INSERTED    = 4'd0;
   localparam logic [3:0] STAT_UPDATED     = 4'd1;
   localparam logic [3:0] STAT_FOUND       = 4'd2;
   localparam logic [3:0] STAT_NOT_FOUND   = 4'd3;
   localparam logic [3:0] STAT_DELETED     = 4'd4;
   localparam logic [3:0] STAT_CLEARED     = 4'd5;
   localparam logic [3:0] STAT_EMPTY       = 4'd6;
   localparam logic [3:0] STAT_ALL_CLEARED = 4'd7;
   localparam logic [3:0] STAT_BAD_KEY     = 4'd8;
   localparam logic [3:0] STAT_BAD_INDEX   = 4'd9;
   localparam logic [3:0] STAT_POOL_FULL   = 4'd10;

   localparam logic [7:0] CHAR_DIGIT_LO  = 8'd48;
   localparam logic [7:0] CHAR_DIGIT_HI  = 8'd57;
   localparam logic [7:0] CHAR_LETTER_LO = 8'd65;
   localparam logic [7:0] CHAR_LETTER_HI = 8'd90;

   // sum of squares of the smallest legal key
   localparam logic [17:0] KEY_BIAS = 18'd15745;
   // legal keys give a biased sum below 8601
   localparam int DIV_W = 14;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] mid;
      logic [31:0] hi;
   } val_type;

   typedef struct packed {
      logic [47:0] key;
      val_type     val;
   } node_rec_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HASH,
      S_HEAD_RD,
      S_HEAD,
      S_NODE,
      S_ACT,
      S_ALLOC,
      S_INS1,
      S_INS2,
      S_DEL2,
      S_CB_RD,
      S_CB,
      S_SWEEP
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/core/chkvs_hash.sv
`default_nettype none
module chkvs_hash
   import chkvs_pkg::*;
#(
   parameter int BUCKETS = 1024,
   parameter int BW      = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          go,
   input  wire logic [47:0]   key,
   output logic               done,
   output logic [BW-1:0]      bucket
);

   // floor(x / BUCKETS) as (x * RECIP) >> SHIFT, exact for every x below 2**DIV_W
   localparam int               SHIFT     = DIV_W + $clog2(BUCKETS);
   localparam int               RW        = DIV_W + 2;
   localparam longint           RECIP_VAL = ((longint'(1) << SHIFT) + longint'(BUCKETS) - 1)
                                            / longint'(BUCKETS);
   localparam logic [RW-1:0]    RECIP     = RW'(RECIP_VAL);
   localparam logic [DIV_W-1:0] DIVISOR   = DIV_W'(BUCKETS);

   logic [15:0]         sq_ff [6];
   logic [15:0]         sq_in [6];
   logic [3:0]          stage_ff, stage_in;
   logic [DIV_W-1:0]    x_ff, x_in;
   logic [DIV_W-1:0]    q_ff, q_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [17:0]         sum;
   logic [DIV_W+RW-1:0] prod;
   logic [2*DIV_W-1:0]  qd;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         sq_in[i] = 16'(key[47-8*i -: 8]) * 16'(key[47-8*i -: 8]);
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < 6; i++) begin
         sum = sum + 18'(sq_ff[i]);
      end
   end

   // squares, biased sum, quotient, remainder: each step is registered
   assign x_in     = DIV_W'(sum - KEY_BIAS);
   assign prod     = x_ff * RECIP;
   assign q_in     = DIV_W'(prod >> SHIFT);
   assign qd       = q_ff * DIVISOR;
   assign rem_in   = x_ff - DIV_W'(qd);
   assign stage_in = {stage_ff[2:0], go};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         for (int i = 0; i < 6; i++) begin
            sq_ff[i] <= sq_in[i];
         end
      end
      x_ff   <= x_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done   = stage_ff[3];
   assign bucket = rem_ff[BW-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/chained_hash_key_value_store_unit.sv
`default_nettype none
// Chained hash key/value store. A transaction is taken when start is high and busy is low;
// its single result shows on the rsp_ ports for one cycle with rsp_valid and cannot be
// held off. Bad keys, bad indexes and unknown ops answer on the next cycle. Insert,
// search and delete first hash the key (squares, their sum, then a reciprocal multiply
// and subtract for the modulo), then walk node memory, which reads one node per cycle;
// insert of a new key and delete finish with memory writes. Clear bucket reads the
// bucket head and tail, then moves the whole chain onto the free list. Clear all
// sweeps the bucket head memory one entry per cycle; the same sweep runs after reset,
// with busy high.
module chained_hash_key_value_store_unit
   import chkvs_pkg::*;
#(
   parameter int BUCKETS    = 1024,
   parameter int POOL_NODES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_op,
   input  wire logic [47:0] req_key,
   input  wire logic [63:0] req_value_lo,
   input  wire logic [63:0] req_value_mid,
   input  wire logic [31:0] req_value_hi,
   input  wire logic [11:0] req_bucket,
   output logic             rsp_valid,
   output logic [3:0]       rsp_status,
   output logic [63:0]      rsp_found_lo,
   output logic [63:0]      rsp_found_mid,
   output logic [31:0]      rsp_found_hi,
   output logic [11:0]      rsp_hashed_bucket
);

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int NW = $clog2(POOL_NODES + 1);
   localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

   // storage
   logic [NW-1:0] head_mem [BUCKETS];
   logic [NW-1:0] tail_mem [BUCKETS];
   node_rec_type  node_mem [POOL_NODES];
   logic [NW-1:0] link_mem [POOL_NODES];

   logic [NW-1:0] head_rd_ff, tail_rd_ff, link_rd_ff;
   node_rec_type  node_rd_ff;

   logic          head_we, tail_we, nd_we, lk_we;
   logic [BW-1:0] head_waddr;
   logic [NW-1:0] head_wdata, tail_wdata, lk_wdata;
   logic [AW-1:0] nd_waddr, lk_waddr;
   node_rec_type  nd_wdata;
   logic [NW-1:0] nd_raddr;

   state_type     state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [47:0]   key_ff, key_in;
   val_type       val_ff, val_in;
   logic [BW-1:0] bidx_ff, bidx_in;
   logic [11:0]   hb_ff, hb_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] prev_ff, prev_in;
   logic [NW-1:0] link_ff, link_in;
   logic [NW-1:0] headv_ff, headv_in;
   logic [NW-1:0] tail_ff, tail_in;
   logic [NW-1:0] n_ff, n_in;
   val_type       fv_ff, fv_in;
   logic [NW-1:0] free_ff, free_in;
   logic [NW-1:0] fresh_ff, fresh_in;
   logic [BW-1:0] sweep_ff, sweep_in;
   logic          report_ff, report_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [3:0]    rsp_status_ff, rsp_status_in;
   val_type       rsp_fv_ff, rsp_fv_in;
   logic [11:0]   rsp_hb_ff, rsp_hb_in;

   logic          accept;
   logic          key_ok;
   logic          idx_bad;
   logic          found;
   logic          prev_is_node;
   logic          head_empty;
   logic          match;
   logic          sweep_last;
   logic          free_avail;
   logic          fresh_avail;
   logic          h_go;
   logic          h_done;
   logic [BW-1:0] h_bucket;

   chkvs_hash #(
      .BUCKETS (BUCKETS),
      .BW      (BW)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .go     (h_go),
      .key    (req_key),
      .done   (h_done),
      .bucket (h_bucket)
   );

   assign accept = start && !busy;

   always_comb begin
      key_ok = 1'b1;
      for (int i = 0; i < 6; i++) begin
         if (i == 3) begin
            if (req_key[47-8*i -: 8] < CHAR_LETTER_LO || req_key[47-8*i -: 8] > CHAR_LETTER_HI)
               key_ok = 1'b0;
         end else begin
            if (req_key[47-8*i -: 8] < CHAR_DIGIT_LO || req_key[47-8*i -: 8] > CHAR_DIGIT_HI)
               key_ok = 1'b0;
         end
      end
   end

   assign idx_bad      = {1'b0, req_bucket} >= 13'(BUCKETS);
   assign found        = cur_ff < NIL;
   assign prev_is_node = prev_ff < NIL;
   assign head_empty   = !(head_rd_ff < NIL);
   assign match        = node_rd_ff.key == key_ff;
   assign sweep_last   = sweep_ff == BW'(BUCKETS - 1);
   assign free_avail   = free_ff < NIL;
   assign fresh_avail  = fresh_ff < NIL;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op) inside
                  OP_INSERT, OP_SEARCH, OP_DELETE: if (key_ok) state_in = S_HASH;
                  OP_CLR_BUCKET:                   if (!idx_bad) state_in = S_CB_RD;
                  OP_CLR_ALL:                      state_in = S_SWEEP;
                  default:                         state_in = S_IDLE;
               endcase
            end
         end
         S_HASH:    if (h_done) state_in = S_HEAD_RD;
         S_HEAD_RD: state_in = S_HEAD;
         S_HEAD:    state_in = head_empty ? S_ACT : S_NODE;
         S_NODE:    if (match || !(link_rd_ff < NIL)) state_in = S_ACT;
         S_ACT: begin
            state_in = S_IDLE;
            if (op_ff == OP_INSERT && !found) begin
               if (free_avail)       state_in = S_ALLOC;
               else if (fresh_avail) state_in = S_INS1;
            end else if (op_ff == OP_DELETE && found && prev_is_node) begin
               state_in = S_DEL2;
            end
         end
         S_ALLOC:   state_in = S_INS1;
         S_INS1:    state_in = (headv_ff < NIL) ? S_INS2 : S_IDLE;
         S_INS2:    state_in = S_IDLE;
         S_DEL2:    state_in = S_IDLE;
         S_CB_RD:   state_in = S_CB;
         S_CB:      state_in = S_IDLE;
         S_SWEEP:   if (sweep_last) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in      = op_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      bidx_in    = bidx_ff;
      hb_in      = hb_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      link_in    = link_ff;
      headv_in   = headv_ff;
      tail_in    = tail_ff;
      n_in       = n_ff;
      fv_in      = fv_ff;
      free_in    = free_ff;
      fresh_in   = fresh_ff;
      sweep_in   = sweep_ff;
      report_in  = report_ff;
      h_go       = 1'b0;
      nd_raddr   = cur_ff;
      head_we    = 1'b0;
      head_waddr = bidx_ff;
      head_wdata = NIL;
      tail_we    = 1'b0;
      tail_wdata = n_ff;
      nd_we      = 1'b0;
      nd_waddr   = n_ff[AW-1:0];
      nd_wdata   = '{key: key_ff, val: val_ff};
      lk_we      = 1'b0;
      lk_waddr   = n_ff[AW-1:0];
      lk_wdata   = NIL;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_BAD_INDEX;
      rsp_fv_in     = '0;
      rsp_hb_in     = hb_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req_op;
               key_in = req_key;
               val_in = '{lo: req_value_lo, mid: req_value_mid, hi: req_value_hi};
               hb_in  = '0;
               rsp_hb_in = '0;
               case (req_op) inside
                  OP_INSERT, OP_SEARCH, OP_DELETE: begin
                     if (key_ok) begin
                        h_go = 1'b1;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_BAD_KEY;
                     end
                  end
                  OP_CLR_BUCKET: begin
                     if (idx_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_BAD_INDEX;
                     end else begin
                        bidx_in = req_bucket[BW-1:0];
                     end
                  end
                  OP_CLR_ALL: begin
                     sweep_in  = '0;
                     report_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_BAD_INDEX;
                  end
               endcase
            end
         end
         S_HASH: begin
            if (h_done) begin
               bidx_in = h_bucket;
               hb_in   = 12'(h_bucket);
            end
         end
         S_HEAD: begin
            headv_in = head_rd_ff;
            tail_in  = tail_rd_ff;
            prev_in  = NIL;
            cur_in   = head_rd_ff;
            nd_raddr = head_rd_ff;
         end
         S_NODE: begin
            if (match) begin
               link_in = link_rd_ff;
               fv_in   = node_rd_ff.val;
            end else begin
               // step to the next node, the read follows the link at once
               prev_in  = cur_ff;
               cur_in   = link_rd_ff;
               nd_raddr = link_rd_ff;
            end
         end
         S_ACT: begin
            case (op_ff)
               OP_SEARCH: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = found ? STAT_FOUND : STAT_NOT_FOUND;
                  if (found) rsp_fv_in = fv_ff;
               end
               OP_INSERT: begin
                  if (found) begin
                     nd_we         = 1'b1;
                     nd_waddr      = cur_ff[AW-1:0];
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_UPDATED;
                  end else if (free_avail) begin
                     nd_raddr = free_ff;
                  end else if (fresh_avail) begin
                     n_in     = fresh_ff;
                     fresh_in = fresh_ff + NW'(1);
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_POOL_FULL;
                  end
               end
               OP_DELETE: begin
                  if (found) begin
                     lk_we    = 1'b1;
                     lk_waddr = cur_ff[AW-1:0];
                     lk_wdata = free_ff;
                     free_in  = cur_ff;
                     if (!prev_is_node) begin
                        head_we    = 1'b1;
                        head_wdata = link_ff;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_DELETED;
                     end
                     if (tail_ff == cur_ff) begin
                        tail_we    = 1'b1;
                        tail_wdata = prev_is_node ? prev_ff : '0;
                     end
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_NOT_FOUND;
                  end
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_BAD_INDEX;
               end
            endcase
         end
         S_ALLOC: begin
            n_in    = free_ff;
            free_in = link_rd_ff;
         end
         S_INS1: begin
            nd_we   = 1'b1;
            lk_we   = 1'b1;
            tail_we = 1'b1;
            if (!(headv_ff < NIL)) begin
               head_we       = 1'b1;
               head_wdata    = n_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_INSERTED;
            end
         end
         S_INS2: begin
            lk_we         = 1'b1;
            lk_waddr      = tail_ff[AW-1:0];
            lk_wdata      = n_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_INSERTED;
         end
         S_DEL2: begin
            lk_we         = 1'b1;
            lk_waddr      = prev_ff[AW-1:0];
            lk_wdata      = link_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_DELETED;
         end
         S_CB: begin
            rsp_valid_in = 1'b1;
            if (head_empty) begin
               rsp_status_in = STAT_EMPTY;
            end else begin
               // whole chain goes onto the free list
               lk_we         = 1'b1;
               lk_waddr      = tail_rd_ff[AW-1:0];
               lk_wdata      = free_ff;
               free_in       = head_rd_ff;
               head_we       = 1'b1;
               rsp_status_in = STAT_CLEARED;
            end
         end
         S_SWEEP: begin
            head_we    = 1'b1;
            head_waddr = sweep_ff;
            sweep_in   = sweep_ff + BW'(1);
            if (sweep_last) begin
               free_in   = NIL;
               fresh_in  = '0;
               report_in = 1'b0;
               if (report_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_ALL_CLEARED;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         report_ff    <= 1'b0;
         free_ff      <= NIL;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         report_ff    <= report_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      bidx_ff       <= bidx_in;
      hb_ff         <= hb_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      link_ff       <= link_in;
      headv_ff      <= headv_in;
      tail_ff       <= tail_in;
      n_ff          <= n_in;
      fv_ff         <= fv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fv_ff     <= rsp_fv_in;
      rsp_hb_ff     <= rsp_hb_in;
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_waddr] <= head_wdata;
      head_rd_ff <= head_mem[bidx_ff];
   end

   always_ff @(posedge clock) begin
      if (tail_we) tail_mem[bidx_ff] <= tail_wdata;
      tail_rd_ff <= tail_mem[bidx_ff];
   end

   always_ff @(posedge clock) begin
      if (nd_we) node_mem[nd_waddr] <= nd_wdata;
      node_rd_ff <= node_mem[nd_raddr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (lk_we) link_mem[lk_waddr] <= lk_wdata;
      link_rd_ff <= link_mem[nd_raddr[AW-1:0]];
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_lo      = rsp_fv_ff.lo;
   assign rsp_found_mid     = rsp_fv_ff.mid;
   assign rsp_found_hi      = rsp_fv_ff.hi;
   assign rsp_hashed_bucket = rsp_hb_ff;

endmodule
`default_nettype wire

FILE: rtl/core/chkvs_checker.sv
`default_nettype none
module chkvs_checker
   import chkvs_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic [2:0]  req_op,
   input wire logic        rsp_valid,
   input wire logic [3:0]  rsp_status,
   input wire logic [63:0] rsp_found_lo,
   input wire logic [63:0] rsp_found_mid,
   input wire logic [31:0] rsp_found_hi,
   input wire logic [11:0] rsp_hashed_bucket
);

   // unknown ops answer on the next cycle
   a_unknown_op: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op > OP_CLR_ALL |=> rsp_valid && rsp_status == STAT_BAD_INDEX)
      else $error("unknown op not answered with bad index");

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_FOUND |->
         rsp_found_lo == '0 && rsp_found_mid == '0 && rsp_found_hi == '0)
      else $error("found value nonzero without a hit");

   a_no_bucket: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_CLEARED || rsp_status == STAT_EMPTY ||
         rsp_status == STAT_ALL_CLEARED || rsp_status == STAT_BAD_KEY ||
         rsp_status == STAT_BAD_INDEX) |-> rsp_hashed_bucket == '0)
      else $error("hashed bucket reported where no key was hashed");

   // the head memory sweep runs right after reset
   a_reset_sweep: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("block idle right after reset");

endmodule

bind chained_hash_key_value_store_unit chkvs_checker u_chkvs_checker (.*);
`default_nettype wire
